FILE: rtl/core/cfs_pkg.sv
// Shared types, constants and the control store of the coprime filter sieve.
`timescale 1ns / 1ps

package cfs_pkg;

  // Default bitmap depth: one mark bit for each integer below this bound.
  localparam int MAX_VALUE_DEF = 262144;

  // Width of the value field, and of the trial divisor and its square.
  localparam int VALUE_W = 18;
  localparam int ROOT_W  = VALUE_W / 2 + 1;
  localparam int SQ_W    = VALUE_W + 1;

  // Quotient bits the divider retires per cycle, and the steps of one division.
  localparam int DIV_BITS   = 3;
  localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [VALUE_W-1:0] value;
  } cfs_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] candidate;
    logic               is_coprime;
  } cfs_out_t;

  // Microprogram step addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CLR   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DIVW  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TESTR = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MARKD = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MARKQ = 4'd6;
  localparam logic [STEP_W-1:0] STEP_QWAIT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_NEXT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DONE  = 4'd9;

  // Jump condition codes.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_ALWAYS = 3'd0;
  localparam logic [COND_W-1:0] COND_START  = 3'd1;
  localparam logic [COND_W-1:0] COND_FIN    = 3'd2;
  localparam logic [COND_W-1:0] COND_DIVB   = 3'd3;
  localparam logic [COND_W-1:0] COND_REMNZ  = 3'd4;
  localparam logic [COND_W-1:0] COND_CLRL   = 3'd5;

  // One control word: a conditional jump plus the datapath actions of the step.
  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] nxt_t;
    logic [STEP_W-1:0] nxt_f;
    logic              busy;
    logic              accept;
    logic              div_go;
    logic              mem_d;
    logic              mem_q;
    logic              step;
    logic              done;
    logic              clr;
  } cfs_ucw_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic start;
    logic fin;
    logic div_busy;
    logic rem_nz;
    logic clr_last;
  } cfs_flags_t;

  function automatic cfs_ucw_t ucode_rom(input logic [STEP_W-1:0] upc);
    cfs_ucw_t w;
    w = '0;
    unique case (upc)
      STEP_CLR: begin
        w.cond = COND_CLRL; w.nxt_t = STEP_IDLE; w.nxt_f = STEP_CLR;
        w.busy = 1'b1; w.clr = 1'b1;
      end
      STEP_IDLE: begin
        w.cond = COND_START; w.nxt_t = STEP_CHECK; w.nxt_f = STEP_IDLE;
        w.accept = 1'b1;
      end
      STEP_CHECK: begin
        w.cond = COND_FIN; w.nxt_t = STEP_DONE; w.nxt_f = STEP_DIVW;
        w.busy = 1'b1; w.div_go = 1'b1;
      end
      STEP_DIVW: begin
        w.cond = COND_DIVB; w.nxt_t = STEP_DIVW; w.nxt_f = STEP_TESTR;
        w.busy = 1'b1;
      end
      STEP_TESTR: begin
        w.cond = COND_REMNZ; w.nxt_t = STEP_NEXT; w.nxt_f = STEP_MARKD;
        w.busy = 1'b1;
      end
      STEP_MARKD: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_MARKQ; w.nxt_f = STEP_MARKQ;
        w.busy = 1'b1; w.mem_d = 1'b1;
      end
      STEP_MARKQ: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_QWAIT; w.nxt_f = STEP_QWAIT;
        w.busy = 1'b1; w.mem_q = 1'b1;
      end
      STEP_QWAIT: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_NEXT; w.nxt_f = STEP_NEXT;
        w.busy = 1'b1;
      end
      STEP_NEXT: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_CHECK; w.nxt_f = STEP_CHECK;
        w.busy = 1'b1; w.step = 1'b1;
      end
      STEP_DONE: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_IDLE; w.nxt_f = STEP_IDLE;
        w.busy = 1'b1; w.done = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS; w.nxt_t = STEP_CLR; w.nxt_f = STEP_CLR;
        w.busy = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/cfs_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module cfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/cfs_div.sv
// Restoring divider that retires a few quotient bits per cycle.
`timescale 1ns / 1ps

module cfs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cfs_pkg::VALUE_W-1:0] dividend,
  input  logic [cfs_pkg::ROOT_W-1:0]  divisor,
  output logic                        busy,
  output logic [cfs_pkg::VALUE_W-1:0] quotient,
  output logic [cfs_pkg::ROOT_W-1:0]  remainder
);

  localparam logic [cfs_pkg::DIV_CNT_W-1:0] CNT_LAST =
    cfs_pkg::DIV_CNT_W'(cfs_pkg::DIV_CYCLES - 1);

  logic                           busy_r;
  logic [cfs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [cfs_pkg::ROOT_W-1:0]     rem_r, rem_nxt;
  logic [cfs_pkg::VALUE_W-1:0]    quo_r, quo_nxt;
  logic [cfs_pkg::ROOT_W-1:0]     div_r;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  always_comb begin
    logic [cfs_pkg::ROOT_W:0] t;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < cfs_pkg::DIV_BITS; i++) begin
      t       = {rem_nxt, quo_nxt[cfs_pkg::VALUE_W-1]};
      quo_nxt = {quo_nxt[cfs_pkg::VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t          = t - {1'b0, div_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = t[cfs_pkg::ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/cfs_seq.sv
// Microprogram sequencer: step counter, control store lookup and jumps.
`timescale 1ns / 1ps

module cfs_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfs_pkg::cfs_flags_t  flags,
  output cfs_pkg::cfs_ucw_t    ucw
);

  logic [cfs_pkg::STEP_W-1:0] upc_r, upc_nxt;
  logic                       taken;

  assign ucw = cfs_pkg::ucode_rom(upc_r);

  always_comb begin
    unique case (ucw.cond)
      cfs_pkg::COND_ALWAYS: taken = 1'b1;
      cfs_pkg::COND_START:  taken = flags.start;
      cfs_pkg::COND_FIN:    taken = flags.fin;
      cfs_pkg::COND_DIVB:   taken = flags.div_busy;
      cfs_pkg::COND_REMNZ:  taken = flags.rem_nz;
      cfs_pkg::COND_CLRL:   taken = flags.clr_last;
      default:              taken = 1'b1;
    endcase
    upc_nxt = taken ? ucw.nxt_t : ucw.nxt_f;
  end

  // Reset enters the bitmap clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= cfs_pkg::STEP_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: rtl/core/coprime_filter_sieve_unit.sv
// Top level of the coprime filter sieve: divisor marking bitmap and query unit.
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Handshake
// input     start, busy, in_data           in         taken when start && !busy
// result    out_strobe, out_data           out        one-cycle strobe, no back-pressure
//
// An item walks the trial divisors d = 1, 2, ... while d*d <= value. For each
// divisor the divider (3 quotient bits per cycle) and the microprogram around
// it work out the remainder; when d divides the value, the bitmap is accessed
// for d and value/d in turn on the single RAM port.
// After reset the block sweeps the bitmap clear, one bit per cycle, over all
// MAX_VALUE bits with busy high. A query result appears the cycle after its
// last step, and busy is low again in that same cycle.

module coprime_filter_sieve_unit #(
  parameter int MAX_VALUE = cfs_pkg::MAX_VALUE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cfs_pkg::cfs_in_t  in_data,
  output logic              out_strobe,
  output cfs_pkg::cfs_out_t out_data
);

  localparam int ADDR_W = $clog2(MAX_VALUE);
  // Compare width that holds both a value and the bitmap bound.
  localparam int CMP_W  = ADDR_W + cfs_pkg::VALUE_W + 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_VALUE - 1);

  cfs_pkg::cfs_ucw_t   ucw;
  cfs_pkg::cfs_flags_t flags;

  logic                          op_r;
  logic [cfs_pkg::VALUE_W-1:0]   v_r;
  logic [cfs_pkg::ROOT_W-1:0]    d_r;
  logic [cfs_pkg::SQ_W-1:0]      sq_r;
  logic                          hit_r;
  logic [ADDR_W-1:0]             clr_cnt_r;
  logic                          rd_vld_r;
  logic                          out_strobe_r;
  cfs_pkg::cfs_out_t             out_data_r;

  logic                          accept;
  logic                          fin;
  logic                          div_busy;
  logic [cfs_pkg::VALUE_W-1:0]   quo;
  logic [cfs_pkg::ROOT_W-1:0]    rem;
  logic [cfs_pkg::VALUE_W-1:0]   mem_val;
  logic                          in_range;
  logic                          mem_acc;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_addr;
  logic                          mem_wdata;
  logic                          mem_rdata;

  assign accept = ucw.accept & start;
  assign busy   = ucw.busy;

  // The walk ends at a zero value (no divisors) or once d*d passes the value.
  assign fin = (v_r == '0) | (sq_r > {1'b0, v_r});

  assign flags.start    = start;
  assign flags.fin      = fin;
  assign flags.div_busy = div_busy;
  assign flags.rem_nz   = (rem != '0);
  assign flags.clr_last = (clr_cnt_r == CLR_LAST);

  cfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ucw   (ucw)
  );

  cfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ucw.div_go & ~fin),
    .dividend  (v_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  // The bitmap is touched for the divisor d, then for its cofactor value/d.
  // Only divisors above one and below the bitmap bound have a mark bit.
  assign mem_val  = ucw.mem_d ? cfs_pkg::VALUE_W'(d_r) : quo;
  assign in_range = (mem_val > cfs_pkg::VALUE_W'(1)) &&
                    (CMP_W'(mem_val) < CMP_W'(MAX_VALUE));
  assign mem_acc  = (ucw.mem_d | ucw.mem_q) & in_range;

  // The clearing sweep writes zeros; a load writes ones.
  assign mem_we    = ucw.clr | (mem_acc & (op_r == cfs_pkg::OP_LOAD));
  assign mem_addr  = ucw.clr ? clr_cnt_r : ADDR_W'(mem_val);
  assign mem_wdata = ~ucw.clr;

  cfs_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VALUE)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (ucw.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // Read data comes back in the cycle after a query reads the bitmap.
      rd_vld_r     <= mem_acc & (op_r == cfs_pkg::OP_QUERY);
      out_strobe_r <= ucw.done & (op_r == cfs_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.operation;
      v_r   <= in_data.value;
      d_r   <= cfs_pkg::ROOT_W'(1);
      sq_r  <= cfs_pkg::SQ_W'(1);
      hit_r <= 1'b0;
    end else begin
      if (ucw.step) begin
        // (d+1)^2 = d^2 + 2d + 1
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + cfs_pkg::SQ_W'({d_r, 1'b1});
      end
      if (rd_vld_r & mem_rdata) begin
        hit_r <= 1'b1;
      end
    end
    if (ucw.done) begin
      out_data_r.candidate  <= v_r;
      out_data_r.is_coprime <= ~hit_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: rtl/core/cfs_checker.sv
// Port-level checks of the coprime filter sieve, bound to its top level.
`timescale 1ns / 1ps

module cfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input cfs_pkg::cfs_out_t out_data,
  input logic              out_strobe
);

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result always ends a busy stretch.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  // At most one result per item, so strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Zero and one have no divisor above one and are always coprime.
  a_trivial_coprime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.candidate == '0 ||
                    out_data.candidate == cfs_pkg::VALUE_W'(1)))
      |-> out_data.is_coprime)
    else $error("zero or one reported as not coprime");

endmodule

bind coprime_filter_sieve_unit cfs_checker u_cfs_checker (.*);

FILE: tb/sv/tb_coprime_filter_sieve_unit.sv
// Self-checking testbench for the coprime filter sieve unit.
`timescale 1ns / 1ps

module tb_coprime_filter_sieve_unit;

  // The bitmap covers every integer below this bound; with an 18-bit value
  // field no divisor ever lands outside it, but the predictor still guards.
  localparam int MAP_DEPTH = cfs_pkg::MAX_VALUE_DEF;

  // The longest stretch without any accepted item or result is the clearing
  // sweep after reset (one bit per cycle over the whole bitmap). The quiet
  // limit allows that several times over.
  localparam int QUIET_LIMIT = 4 * MAP_DEPTH;

  // One item at the top of the value range walks 511 trial divisors, each
  // with a division, plus the bitmap accesses. The drain after the last
  // expected result covers one such item.
  localparam int DRAIN_CYCLES = 6000;

  localparam int RANDOM_PER_PHASE = 186;
  localparam int N_DIRECTED       = 24;

  // Width of one packed input item.
  localparam int IN_W = cfs_pkg::VALUE_W + 1;

  // How the directed table supplies the expected answer of a row.
  typedef enum logic [1:0] {
    ANS_NONE,
    ANS_PREDICT,
    ANS_COPRIME,
    ANS_NOT_COPRIME
  } answer_t;

  typedef struct packed {
    logic                        operation;
    logic [cfs_pkg::VALUE_W-1:0] value;
    answer_t                     answer;
  } directed_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  cfs_pkg::cfs_in_t  in_data;
  logic              out_strobe;
  cfs_pkg::cfs_out_t out_data;

  // Predictor state: one mark bit per integer, cleared at reset like the block.
  bit                divisor_mark [MAP_DEPTH];
  // Answers owed by the block, oldest first.
  cfs_pkg::cfs_out_t answers_due [$];
  // Small values loaded so far, used to build queries that share a divisor.
  int                loaded_values [$];

  int                sender_idle_pct;
  int                mismatch_count;
  int                quiet_cycles;

  // Directed items: extremes of the value field, zero and one, loads that
  // mark nothing, a perfect square, a large prime and its multiple. Answers
  // are typed in where they are plain; the rest go through the predictor.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{cfs_pkg::OP_QUERY, 18'h3FFFF, ANS_COPRIME},     // nothing is marked after the sweep
    '{cfs_pkg::OP_QUERY, 18'd0,     ANS_COPRIME},     // zero has no divisor at all
    '{cfs_pkg::OP_QUERY, 18'd1,     ANS_COPRIME},     // one is always coprime
    '{cfs_pkg::OP_LOAD,  18'd0,     ANS_NONE},        // loading zero marks nothing
    '{cfs_pkg::OP_QUERY, 18'd6,     ANS_COPRIME},
    '{cfs_pkg::OP_LOAD,  18'd1,     ANS_NONE},        // loading one marks nothing either
    '{cfs_pkg::OP_QUERY, 18'd2,     ANS_COPRIME},
    '{cfs_pkg::OP_LOAD,  18'd12,    ANS_NONE},
    '{cfs_pkg::OP_QUERY, 18'd12,    ANS_NOT_COPRIME}, // every divisor of 12 is now marked
    '{cfs_pkg::OP_QUERY, 18'd35,    ANS_PREDICT},
    '{cfs_pkg::OP_QUERY, 18'd9,     ANS_PREDICT},
    '{cfs_pkg::OP_QUERY, 18'd1,     ANS_COPRIME},
    '{cfs_pkg::OP_QUERY, 18'd0,     ANS_COPRIME},
    '{cfs_pkg::OP_LOAD,  18'h3FFFF, ANS_NONE},        // all-ones value, longest walk
    '{cfs_pkg::OP_QUERY, 18'h20000, ANS_PREDICT},
    '{cfs_pkg::OP_LOAD,  18'h1FFFF, ANS_NONE},        // a prime: marks only itself
    '{cfs_pkg::OP_QUERY, 18'h1FFFF, ANS_NOT_COPRIME},
    '{cfs_pkg::OP_QUERY, 18'h3FFFE, ANS_PREDICT},
    '{cfs_pkg::OP_LOAD,  18'h10000, ANS_NONE},
    '{cfs_pkg::OP_LOAD,  18'd25,    ANS_NONE},        // perfect square, root met once
    '{cfs_pkg::OP_QUERY, 18'd5,     ANS_NOT_COPRIME},
    '{cfs_pkg::OP_QUERY, 18'h2AAAA, ANS_PREDICT},
    '{cfs_pkg::OP_QUERY, 18'h15555, ANS_PREDICT},
    '{cfs_pkg::OP_QUERY, 18'd11,    ANS_PREDICT}
  };

  coprime_filter_sieve_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Marks every divisor above one of a loaded value, found in pairs by trial
  // division up to the square root. Zero has no divisor and marks nothing.
  function automatic void mark_divisors(input int v);
    int d;
    for (d = 1; d * d <= v; d++) begin
      if (v % d == 0) begin
        if (d > 1 && d < MAP_DEPTH) divisor_mark[d] = 1'b1;
        if (v / d > 1 && v / d < MAP_DEPTH) divisor_mark[v / d] = 1'b1;
      end
    end
  endfunction

  // True when some divisor above one of the candidate is already marked.
  function automatic bit has_marked_divisor(input int v);
    int d;
    for (d = 1; d * d <= v; d++) begin
      if (v % d == 0) begin
        if (d > 1 && d < MAP_DEPTH && divisor_mark[d]) return 1'b1;
        if (v / d > 1 && v / d < MAP_DEPTH && divisor_mark[v / d]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Smallest prime not below v; used to pick loads and queries that are
  // unlikely to share a divisor with what is already marked.
  function automatic int first_prime_from(input int v);
    int d;
    bit composite;
    v = (v < 2) ? 1 : v - 1;
    do begin
      v++;
      composite = 1'b0;
      for (d = 2; d * d <= v; d++) begin
        if (v % d == 0) composite = 1'b1;
      end
    end while (composite);
    return v;
  endfunction

  // Random item. Most values stay below 4096 so that each walk is short; a
  // tenth or so span the whole 18-bit field. Loads are a minority, otherwise
  // nearly every small number would soon share a marked divisor. Queries mix
  // plain random values, primes (likely coprime) and multiples of loaded
  // values (certainly not coprime).
  function automatic cfs_pkg::cfs_in_t draw_item();
    cfs_pkg::cfs_in_t item;
    int pick;
    int v;
    int base;
    pick = $urandom_range(0, 99);
    item.operation = ($urandom_range(0, 99) < 15) ? cfs_pkg::OP_LOAD : cfs_pkg::OP_QUERY;
    if (item.operation == cfs_pkg::OP_LOAD) begin
      if (pick < 50) v = first_prime_from($urandom_range(200, 4000));
      else if (pick < 90) v = $urandom_range(0, 4095);
      else v = $urandom_range(0, 262143);
      if (v >= 2 && v <= 4095) loaded_values = {loaded_values, v};
    end else begin
      if (pick < 5) begin
        v = $urandom_range(0, 1);
      end else if (pick < 45) begin
        v = $urandom_range(0, 4095);
      end else if (pick < 70) begin
        v = first_prime_from($urandom_range(2, 4000));
      end else if (pick < 90 && loaded_values.size() != 0) begin
        base = loaded_values[$urandom_range(0, loaded_values.size() - 1)];
        v = base * $urandom_range(1, 4095 / base);
      end else begin
        v = $urandom_range(0, 262143);
      end
    end
    item.value = v[cfs_pkg::VALUE_W-1:0];
    return item;
  endfunction

  // Presents one item after a random number of idle cycles, holds it until
  // the block takes it, then updates the predictor. busy is read right after
  // the edge, so it is the value the block saw at that edge.
  task automatic offer_item(input cfs_pkg::cfs_in_t item, input answer_t answer);
    cfs_pkg::cfs_out_t due;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start   <= 1'b0;
      in_data <= cfs_pkg::cfs_in_t'(IN_W'($urandom()));
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    if (item.operation == cfs_pkg::OP_LOAD) begin
      mark_divisors(item.value);
    end else begin
      due.candidate = item.value;
      case (answer)
        ANS_COPRIME:     due.is_coprime = 1'b1;
        ANS_NOT_COPRIME: due.is_coprime = 1'b0;
        default:         due.is_coprime = !has_marked_divisor(item.value);
      endcase
      answers_due = {answers_due, due};
    end
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %0d, got %0d", mismatch_count, what, want, got);
  endtask

  // Result checker and watchdog. The block cannot hold results back, so each
  // strobe is taken at the edge that ends its cycle and matched against the
  // oldest owed answer.
  always @(posedge clk) begin
    cfs_pkg::cfs_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result, candidate", -1, out_data.candidate);
        end else begin
          want = answers_due.pop_front();
          if (out_data.candidate !== want.candidate)
            report_mismatch("candidate", want.candidate, out_data.candidate);
          if (out_data.is_coprime !== want.is_coprime)
            report_mismatch("is_coprime", want.is_coprime, out_data.is_coprime);
        end
      end
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[coprime_filter_sieve_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int row;
    int phase;
    int n;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_data         <= '0;
    sender_idle_pct = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The first item waits out the clearing sweep through the handshake.
    for (row = 0; row < N_DIRECTED; row++) begin
      offer_item('{operation: directed_rows[row].operation,
                   value:     directed_rows[row].value},
                 directed_rows[row].answer);
    end

    // Random part in three phases: light sender idling, heavy idling, none.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 8;
        1:       sender_idle_pct = 46;
        default: sender_idle_pct = 0;
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) offer_item(draw_item(), ANS_PREDICT);
    end
    start <= 1'b0;

    // A trailing load gives no result, so wait out one full walk as well.
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("[coprime_filter_sieve_unit] OK");
    end else begin
      $display("[coprime_filter_sieve_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cfs_pkg.sv
rtl/core/cfs_ram.sv
rtl/core/cfs_div.sv
rtl/core/cfs_seq.sv
rtl/core/coprime_filter_sieve_unit.sv
rtl/core/cfs_checker.sv
tb/sv/tb_coprime_filter_sieve_unit.sv
